[rtl/core/lzpd_pkg.sv]
// ============================================================================
// lzpd_pkg
// Shared types, codes and header decoding for the page decompressor.
// ============================================================================
`default_nettype none

package lzpd_pkg;

  localparam int PAGE_BYTES_DEF = 4096;

  // Page status codes
  localparam logic [2:0] ST_RUNNING = 3'd0;
  localparam logic [2:0] ST_END     = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_EXHAUST = 3'd3;
  localparam logic [2:0] ST_BAD     = 3'd4;

  // Token decode phases
  localparam logic [2:0] PH_HDR     = 3'd0;
  localparam logic [2:0] PH_RUNLEN  = 3'd1;
  localparam logic [2:0] PH_RUNBYTE = 3'd2;
  localparam logic [2:0] PH_LIT     = 3'd3;
  localparam logic [2:0] PH_HDR1    = 3'd4;
  localparam logic [2:0] PH_HDR2    = 3'd5;

  // Token kinds from the low two bits of the first header byte
  localparam logic [1:0] TK_SHORT = 2'b00;
  localparam logic [1:0] TK_MID   = 2'b01;
  localparam logic [1:0] TK_COPY  = 2'b10;
  localparam logic [1:0] TK_LONG  = 2'b11;

  typedef struct packed {
    logic [5:0]  lits;
    logic [5:0]  cnt;
    logic [11:0] offs;
  } hsize_t;

  // Controller to datapath commands
  typedef struct packed {
    logic take;
    logic decode;
    logic lit;
    logic run;
    logic copy_rd;
    logic copy_wr;
    logic done;
    logic beat_init;
    logic emit_rd;
    logic emit_cap;
    logic push;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic fin_zero;
    logic lit_pend;
    logic copy_busy;
    logic run_busy;
    logic eleft_zero;
    logic beat_full;
    logic out_free;
  } sts_t;

  function automatic hsize_t header_sizes(input logic [23:0] hb);
    hsize_t h;
    h = '0;
    case (hb[1:0])
      TK_SHORT: h.lits = hb[7:2];
      TK_MID: begin
        h.lits = {4'b0, hb[3:2]};
        h.cnt  = {3'b0, hb[6:4]} + 6'd3;
        h.offs = {3'b0, hb[15:7]};
      end
      TK_COPY: begin
        h.cnt  = {4'b0, hb[3:2]} + 6'd3;
        h.offs = hb[15:4];
      end
      default: begin
        h.lits = {2'b0, hb[5:2]};
        h.cnt  = hb[11:6];
        h.offs = hb[23:12];
      end
    endcase
    return h;
  endfunction

endpackage

`default_nettype wire

[rtl/core/lzpd_ram.sv]
// ============================================================================
// lzpd_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
`default_nettype none

module lzpd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = lzpd_pkg::PAGE_BYTES_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

[rtl/core/lzpd_datapath.sv]
// ============================================================================
// lzpd_datapath
// Decode state, page store, copy engine and beat assembly.
// ============================================================================
`default_nettype none

module lzpd_datapath #(
  parameter int PAGE_BYTES = lzpd_pkg::PAGE_BYTES_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic [7:0]    in_packed_byte,
  input  wire logic          in_first_of_page,
  input  wire logic          in_last_of_page,
  input  wire lzpd_pkg::cmd_t cmd,
  output lzpd_pkg::sts_t     sts,
  input  wire logic          out_stall,
  output logic               out_valid,
  output logic [7:0]         out_byte0,
  output logic [7:0]         out_byte1,
  output logic [7:0]         out_byte2,
  output logic [7:0]         out_byte3,
  output logic [2:0]         out_byte_count,
  output logic               out_run_last,
  output logic [2:0]         out_page_status,
  output logic [12:0]        out_page_length
);

  localparam int AW  = $clog2(PAGE_BYTES + 1);
  localparam int RAW = $clog2(PAGE_BYTES);
  localparam int CW  = (AW + 1 > 13) ? AW + 1 : 13;

  logic [7:0]    byte_r, byte_nxt;
  logic          last_r, last_nxt;
  logic [AW-1:0] wp_r, wp_nxt, hwm_r, hwm_nxt, ts_r, ts_nxt, ef_r, ef_nxt;
  logic [AW-1:0] epos_r, epos_nxt, eleft_r, eleft_nxt;
  logic [2:0]    phase_r, phase_nxt, fin_r, fin_nxt;
  logic [23:0]   hb_r, hb_nxt;
  logic [5:0]    lits_r, lits_nxt, copy_left_r, copy_left_nxt;
  logic [7:0]    run_left_r, run_left_nxt;
  logic [11:0]   dist_r, dist_nxt;
  logic          lit_pend_r, lit_pend_nxt, cplt_r, cplt_nxt;
  logic          src_zero_r, src_zero_nxt;
  logic [7:0]    bb_r [4];
  logic [7:0]    bb_nxt [4];
  logic [1:0]    bidx_r, bidx_nxt;
  logic [2:0]    bcnt_r, bcnt_nxt;
  logic          ov_r, ov_nxt, olast_r, olast_nxt;
  logic [7:0]    ob_r [4];
  logic [7:0]    ob_nxt [4];
  logic [2:0]    ocnt_r, ocnt_nxt, ostat_r, ostat_nxt;
  logic [12:0]   olen_r, olen_nxt;

  logic [23:0]      hb_dec;
  lzpd_pkg::hsize_t hs;
  logic             ovf, far, hc, drop;
  logic [AW-1:0]    ts_c;
  logic [2:0]       phase_c, fin_c;
  logic [CW-1:0]    src_full;
  logic [AW+12:0]   ep_ext;

  logic             we;
  logic [7:0]       wdata, rdata;
  logic [RAW-1:0]   raddr;

  assign src_full = CW'(wp_r) - CW'(dist_r);
  assign raddr    = cmd.copy_rd ? src_full[RAW-1:0] : epos_r[RAW-1:0];
  assign we       = cmd.lit | cmd.run | cmd.copy_wr;
  assign wdata    = cmd.copy_wr ? (src_zero_r ? 8'd0 : rdata) : byte_r;
  assign ep_ext   = (AW + 13)'(epos_r);

  lzpd_ram #(
    .WIDTH(8),
    .DEPTH(PAGE_BYTES)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(wp_r[RAW-1:0]),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_comb begin
    case (phase_r) inside
      lzpd_pkg::PH_HDR:  hb_dec = {16'd0, byte_r};
      lzpd_pkg::PH_HDR2: hb_dec = {byte_r, hb_r[15:0]};
      lzpd_pkg::PH_RUNLEN, lzpd_pkg::PH_HDR1: hb_dec = {hb_r[23:16], byte_r, hb_r[7:0]};
      default:           hb_dec = hb_r;
    endcase
    hs  = lzpd_pkg::header_sizes(hb_dec);
    ovf = (CW'(wp_r) + CW'(hs.lits) + CW'(hs.cnt)) > CW'(PAGE_BYTES);
    far = (CW'(wp_r) + CW'(hs.lits)) < CW'(hs.offs);
  end

  always_comb begin
    byte_nxt = byte_r;  last_nxt = last_r;
    wp_nxt = wp_r;  hwm_nxt = hwm_r;  ts_nxt = ts_r;  ef_nxt = ef_r;
    epos_nxt = epos_r;  eleft_nxt = eleft_r;
    phase_nxt = phase_r;  fin_nxt = fin_r;  hb_nxt = hb_r;  lits_nxt = lits_r;
    copy_left_nxt = copy_left_r;  run_left_nxt = run_left_r;  dist_nxt = dist_r;
    lit_pend_nxt = lit_pend_r;  cplt_nxt = cplt_r;  src_zero_nxt = src_zero_r;
    bb_nxt = bb_r;  bidx_nxt = bidx_r;  bcnt_nxt = bcnt_r;
    ob_nxt = ob_r;  ocnt_nxt = ocnt_r;  ostat_nxt = ostat_r;
    olen_nxt = olen_r;  olast_nxt = olast_r;
    ov_nxt = ov_r & out_stall;
    hc = 1'b0;  drop = 1'b0;
    ts_c = ts_r;  phase_c = phase_r;  fin_c = fin_r;

    if (cmd.take) begin
      byte_nxt = in_packed_byte;
      last_nxt = in_last_of_page;
      if (in_first_of_page) begin
        wp_nxt = '0;  hwm_nxt = '0;  ts_nxt = '0;
        phase_nxt = lzpd_pkg::PH_HDR;  hb_nxt = '0;  lits_nxt = '0;
        fin_nxt = lzpd_pkg::ST_RUNNING;
      end
    end

    if (cmd.decode) begin
      ef_nxt = ts_r;
      case (phase_r)
        lzpd_pkg::PH_HDR: begin
          hb_nxt = hb_dec;
          if (byte_r[1:0] == lzpd_pkg::TK_SHORT) begin
            if (byte_r == 8'd0) phase_nxt = lzpd_pkg::PH_RUNLEN;
            else hc = 1'b1;
          end else begin
            phase_nxt = lzpd_pkg::PH_HDR1;
          end
        end
        lzpd_pkg::PH_RUNLEN: begin
          if (byte_r == 8'd0) begin
            phase_nxt = lzpd_pkg::PH_HDR;
            fin_nxt   = lzpd_pkg::ST_END;
          end else if ((CW'(wp_r) + CW'(byte_r)) > CW'(PAGE_BYTES)) begin
            drop = 1'b1;
          end else begin
            hb_nxt    = hb_dec;
            phase_nxt = lzpd_pkg::PH_RUNBYTE;
          end
        end
        lzpd_pkg::PH_RUNBYTE: begin
          run_left_nxt = hb_r[15:8];
          cplt_nxt     = 1'b1;
        end
        lzpd_pkg::PH_LIT: begin
          lit_pend_nxt = 1'b1;
          if (lits_r != 6'd0) lits_nxt = lits_r - 6'd1;
          if (lits_r <= 6'd1) begin
            copy_left_nxt = hs.cnt;
            dist_nxt      = hs.offs;
            cplt_nxt      = 1'b1;
          end
        end
        lzpd_pkg::PH_HDR1: begin
          hb_nxt = hb_dec;
          if (hb_dec[1:0] == lzpd_pkg::TK_LONG) phase_nxt = lzpd_pkg::PH_HDR2;
          else hc = 1'b1;
        end
        lzpd_pkg::PH_HDR2: begin
          hb_nxt = hb_dec;
          hc     = 1'b1;
        end
        default: phase_nxt = lzpd_pkg::PH_HDR;
      endcase
      if (hc) begin
        if (ovf || far) begin
          drop = 1'b1;
        end else if (hs.lits != 6'd0) begin
          lits_nxt  = hs.lits;
          phase_nxt = lzpd_pkg::PH_LIT;
        end else begin
          copy_left_nxt = hs.cnt;
          dist_nxt      = hs.offs;
          cplt_nxt      = 1'b1;
        end
      end
      if (drop) begin
        wp_nxt = ts_r;  phase_nxt = lzpd_pkg::PH_HDR;  lits_nxt = '0;
        fin_nxt = lzpd_pkg::ST_BAD;
      end
    end

    // Sequential byte writes; the high-water mark tracks the written prefix
    if (we) begin
      wp_nxt = wp_r + AW'(1);
      if (wp_r >= hwm_r) hwm_nxt = wp_r + AW'(1);
    end
    if (cmd.lit) lit_pend_nxt = 1'b0;
    if (cmd.run) run_left_nxt = run_left_r - 8'd1;
    if (cmd.copy_rd) src_zero_nxt = (dist_r == 12'd0) && (wp_r >= hwm_r);
    if (cmd.copy_wr) copy_left_nxt = copy_left_r - 6'd1;

    if (cmd.done) begin
      if (cplt_r) begin
        phase_c = lzpd_pkg::PH_HDR;
        ts_c    = wp_r;
        if (wp_r >= AW'(PAGE_BYTES)) fin_c = lzpd_pkg::ST_FULL;
      end
      cplt_nxt = 1'b0;  phase_nxt = phase_c;  ts_nxt = ts_c;  fin_nxt = fin_c;
      if (fin_c == lzpd_pkg::ST_RUNNING && last_r) begin
        if (phase_c != lzpd_pkg::PH_HDR) begin
          wp_nxt = ts_c;  phase_nxt = lzpd_pkg::PH_HDR;  lits_nxt = '0;
          fin_nxt = lzpd_pkg::ST_BAD;
        end else begin
          fin_nxt = lzpd_pkg::ST_EXHAUST;
        end
      end
      eleft_nxt = ts_c - ef_r;
      epos_nxt  = ef_r;
    end

    if (cmd.beat_init) begin
      bidx_nxt = '0;
      bcnt_nxt = (eleft_r >= AW'(4)) ? 3'd4 : eleft_r[2:0];
      for (int i = 0; i < 4; i++) bb_nxt[i] = '0;
    end
    if (cmd.emit_cap) begin
      bb_nxt[bidx_r] = rdata;
      bidx_nxt  = bidx_r + 2'd1;
      epos_nxt  = epos_r + AW'(1);
      eleft_nxt = eleft_r - AW'(1);
    end
    if (cmd.push) begin
      ov_nxt    = 1'b1;
      ob_nxt    = bb_r;
      ocnt_nxt  = bcnt_r;
      olast_nxt = (eleft_r == '0);
      ostat_nxt = fin_r;
      olen_nxt  = ep_ext[12:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;  hwm_r <= '0;  ts_r <= '0;  ef_r <= '0;
      epos_r <= '0;  eleft_r <= '0;
      phase_r <= lzpd_pkg::PH_HDR;  fin_r <= lzpd_pkg::ST_RUNNING;
      hb_r <= '0;  lits_r <= '0;  copy_left_r <= '0;  run_left_r <= '0;
      lit_pend_r <= 1'b0;  cplt_r <= 1'b0;
      bidx_r <= '0;  bcnt_r <= '0;  ov_r <= 1'b0;
    end else begin
      wp_r <= wp_nxt;  hwm_r <= hwm_nxt;  ts_r <= ts_nxt;  ef_r <= ef_nxt;
      epos_r <= epos_nxt;  eleft_r <= eleft_nxt;
      phase_r <= phase_nxt;  fin_r <= fin_nxt;
      hb_r <= hb_nxt;  lits_r <= lits_nxt;  copy_left_r <= copy_left_nxt;
      run_left_r <= run_left_nxt;
      lit_pend_r <= lit_pend_nxt;  cplt_r <= cplt_nxt;
      bidx_r <= bidx_nxt;  bcnt_r <= bcnt_nxt;  ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;  last_r <= last_nxt;  dist_r <= dist_nxt;
    src_zero_r <= src_zero_nxt;  bb_r <= bb_nxt;  ob_r <= ob_nxt;
    ocnt_r <= ocnt_nxt;  ostat_r <= ostat_nxt;  olen_r <= olen_nxt;
    olast_r <= olast_nxt;
  end

  assign sts.fin_zero   = (fin_r == lzpd_pkg::ST_RUNNING);
  assign sts.lit_pend   = lit_pend_r;
  assign sts.copy_busy  = (copy_left_r != 6'd0);
  assign sts.run_busy   = (run_left_r != 8'd0);
  assign sts.eleft_zero = (eleft_r == '0);
  assign sts.beat_full  = ((3'(bidx_r) + 3'd1) == bcnt_r);
  assign sts.out_free   = !ov_r || !out_stall;

  assign out_valid       = ov_r;
  assign out_byte0       = ob_r[0];
  assign out_byte1       = ob_r[1];
  assign out_byte2       = ob_r[2];
  assign out_byte3       = ob_r[3];
  assign out_byte_count  = ocnt_r;
  assign out_run_last    = olast_r;
  assign out_page_status = ostat_r;
  assign out_page_length = olen_r;

  a_write_in_page: assert property (@(posedge clk) disable iff (!rst_n)
    we |-> (wp_r < AW'(PAGE_BYTES)))
    else $error("store write beyond page");
  a_start_le_pos: assert property (@(posedge clk) disable iff (!rst_n)
    ts_r <= wp_r)
    else $error("token start ahead of write position");
  a_pos_le_mark: assert property (@(posedge clk) disable iff (!rst_n)
    wp_r <= hwm_r)
    else $error("write position beyond written prefix");
  a_beat_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |=> (out_byte_count <= 3'd4))
    else $error("beat byte count out of range");

endmodule

`default_nettype wire

[rtl/core/lzpd_ctrl.sv]
// ============================================================================
// lzpd_ctrl
// Sequencer: takes one packed byte, steps the write and copy work, then
// walks the finished bytes out in beats.
// ============================================================================
`default_nettype none

module lzpd_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire lzpd_pkg::sts_t sts,
  output lzpd_pkg::cmd_t      cmd
);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_DECODE = 10'b0000000010,
    S_WORK   = 10'b0000000100,
    S_CRD    = 10'b0000001000,
    S_CWR    = 10'b0000010000,
    S_DONE   = 10'b0000100000,
    S_EINIT  = 10'b0001000000,
    S_ERD    = 10'b0010000000,
    S_ECAP   = 10'b0100000000,
    S_BEAT   = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (!sts.fin_zero) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.decode = 1'b1;
          state_nxt  = S_WORK;
        end
      end
      S_WORK: begin
        if (sts.lit_pend) cmd.lit = 1'b1;
        else if (sts.copy_busy) state_nxt = S_CRD;
        else if (sts.run_busy) cmd.run = 1'b1;
        else state_nxt = S_DONE;
      end
      S_CRD: begin
        cmd.copy_rd = 1'b1;
        state_nxt   = S_CWR;
      end
      S_CWR: begin
        cmd.copy_wr = 1'b1;
        state_nxt   = S_WORK;
      end
      S_DONE: begin
        cmd.done  = 1'b1;
        state_nxt = S_EINIT;
      end
      S_EINIT: begin
        if (sts.eleft_zero && sts.fin_zero) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.beat_init = 1'b1;
          state_nxt     = sts.eleft_zero ? S_BEAT : S_ERD;
        end
      end
      S_ERD: begin
        cmd.emit_rd = 1'b1;
        state_nxt   = S_ECAP;
      end
      S_ECAP: begin
        cmd.emit_cap = 1'b1;
        state_nxt    = sts.beat_full ? S_BEAT : S_ERD;
      end
      S_BEAT: begin
        if (sts.out_free) begin
          cmd.push  = 1'b1;
          state_nxt = sts.eleft_zero ? S_IDLE : S_EINIT;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take |=> (state_r == S_DECODE))
    else $error("take did not lead to decode");
  a_copy_pair: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.copy_rd |=> cmd.copy_wr)
    else $error("copy read without write");
  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({cmd.lit, cmd.run, cmd.copy_wr}) <= 1)
    else $error("two store writes in one cycle");

endmodule

`default_nettype wire

[rtl/core/lz_page_decompress.sv]
// ============================================================================
// lz_page_decompress
// Byte-serial page decompressor for the LZ-style packed page format.
// ============================================================================
// One packed byte is taken at a time; the block holds in_stall high until it
// has finished that byte and handed its last result beat to the output
// register. A byte is taken and decoded, then each literal or run byte is
// written, each back-copy byte is dispatched, read from the store and then
// written (so overlapping copies see their own output), and the token is
// closed. Then each beat is set up, its bytes are read and captured one by
// one, and it is handed over, waiting while out_stall holds the output
// register; a byte that leaves no beat finds nothing to emit. The page store
// has one write port and one read port with registered read data. A token's
// bytes come out only when the token completes, four to a beat, with
// out_run_last on its final beat; a page end that produces no bytes shows
// one beat with out_byte_count zero carrying the status. in_first_of_page
// restarts the page; no clearing pass is needed since a written-prefix mark
// makes unwritten store bytes read as zero. After the page ends, further
// bytes are taken and dropped without a beat.
// ============================================================================
`default_nettype none

module lz_page_decompress #(
  parameter int PAGE_BYTES = lzpd_pkg::PAGE_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_packed_byte,
  input  wire logic        in_first_of_page,
  input  wire logic        in_last_of_page,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_byte0,
  output logic [7:0]       out_byte1,
  output logic [7:0]       out_byte2,
  output logic [7:0]       out_byte3,
  output logic [2:0]       out_byte_count,
  output logic             out_run_last,
  output logic [2:0]       out_page_status,
  output logic [12:0]      out_page_length
);

  lzpd_pkg::cmd_t cmd;
  lzpd_pkg::sts_t sts;

  // Sequencer: one request in flight from take to last beat
  lzpd_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sts     (sts),
    .cmd     (cmd)
  );

  // Decode state, page store, copy engine and output register
  lzpd_datapath #(
    .PAGE_BYTES(PAGE_BYTES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_packed_byte  (in_packed_byte),
    .in_first_of_page(in_first_of_page),
    .in_last_of_page (in_last_of_page),
    .cmd             (cmd),
    .sts             (sts),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_byte0       (out_byte0),
    .out_byte1       (out_byte1),
    .out_byte2       (out_byte2),
    .out_byte3       (out_byte3),
    .out_byte_count  (out_byte_count),
    .out_run_last    (out_run_last),
    .out_page_status (out_page_status),
    .out_page_length (out_page_length)
  );

endmodule

`default_nettype wire

[bench/lz_page_decompress_check.sv]
// ----------------------------------------------------------------------------
// lz_page_decompress_check
// Watches both channels of the page decompressor, predicts each request's
// result beats and compares them field by field in arrival order.
// ----------------------------------------------------------------------------
`default_nettype none

module lz_page_decompress_check (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [7:0]  in_packed_byte,
  input  wire logic        in_first_of_page,
  input  wire logic        in_last_of_page,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [7:0]  out_byte0,
  input  wire logic [7:0]  out_byte1,
  input  wire logic [7:0]  out_byte2,
  input  wire logic [7:0]  out_byte3,
  input  wire logic [2:0]  out_byte_count,
  input  wire logic        out_run_last,
  input  wire logic [2:0]  out_page_status,
  input  wire logic [12:0] out_page_length,
  output int               fail_count,
  output int               beats_pending
);
  import lzpd_pkg::*;

  localparam int PB = PAGE_BYTES_DEF;

  typedef struct packed {
    logic [7:0]  b0, b1, b2, b3;
    logic [2:0]  cnt;
    logic        last;
    logic [2:0]  status;
    logic [12:0] len;
  } beat_t;

  beat_t     beat_q[$];
  logic [7:0] mem[PB];
  int        wpos, lits_left, tok_start;
  logic [2:0] phase, fin;
  logic [23:0] hdr;

  function automatic logic [7:0] rd(int a);
    return (a >= 0 && a < PB) ? mem[a] : 8'd0;
  endfunction

  function automatic void clear_page();
    foreach (mem[i]) mem[i] = 8'd0;
    wpos = 0; phase = PH_HDR; hdr = '0; lits_left = 0; tok_start = 0; fin = ST_RUNNING;
  endfunction

  function automatic void drop_token();
    wpos = tok_start; phase = PH_HDR; lits_left = 0; fin = ST_BAD;
  endfunction

  function automatic void close_token();
    phase = PH_HDR; tok_start = wpos;
    if (wpos >= PB) fin = ST_FULL;
  endfunction

  // Decode sizes independently of the package helper.
  function automatic void sizes(output int l, output int c, output int d);
    int w;
    w = hdr[15:0]; l = 0; c = 0; d = 0;
    case (hdr[1:0])
      TK_SHORT: l = hdr[7:2];
      TK_MID: begin l = hdr[3:2]; c = hdr[6:4] + 3; d = w >> 7; end
      TK_COPY: begin c = hdr[3:2] + 3; d = w >> 4; end
      default: begin l = hdr[5:2]; c = (w >> 6) & 63; d = hdr[23:12]; end
    endcase
  endfunction

  function automatic void copy_back();
    int l, c, d;
    sizes(l, c, d);
    for (int i = 0; i < c; i++) begin
      if (wpos < PB) mem[wpos] = rd(wpos - d);
      wpos++;
    end
    close_token();
  endfunction

  function automatic void header_done();
    int l, c, d;
    sizes(l, c, d);
    if (wpos + l + c > PB || wpos + l < d) begin
      drop_token();
    end else if (l > 0) begin
      lits_left = l; phase = PH_LIT;
    end else begin
      copy_back();
    end
  endfunction

  function automatic void decode_byte(logic [7:0] b, logic first, logic last);
    int from, n, nb, c;
    beat_t e;
    if (first) clear_page();
    if (fin != ST_RUNNING) return;
    from = tok_start;
    case (phase)
      PH_HDR: begin
        hdr = {16'd0, b};
        if (b[1:0] == TK_SHORT) begin
          if (b == 0) phase = PH_RUNLEN;
          else header_done();
        end else phase = PH_HDR1;
      end
      PH_RUNLEN: begin
        if (b == 0) begin phase = PH_HDR; fin = ST_END; end
        else if (wpos + b > PB) drop_token();
        else begin hdr[15:8] = b; phase = PH_RUNBYTE; end
      end
      PH_RUNBYTE: begin
        for (int i = 0; i < hdr[15:8]; i++) begin
          if (wpos < PB) mem[wpos] = b;
          wpos++;
        end
        close_token();
      end
      PH_LIT: begin
        if (wpos < PB) mem[wpos] = b;
        wpos++;
        if (lits_left > 0) lits_left--;
        if (lits_left == 0) copy_back();
      end
      PH_HDR1: begin
        hdr[15:8] = b;
        if (hdr[1:0] == TK_LONG) phase = PH_HDR2;
        else header_done();
      end
      PH_HDR2: begin hdr[23:16] = b; header_done(); end
      default: phase = PH_HDR;
    endcase
    if (fin == ST_RUNNING && last) begin
      if (phase != PH_HDR) drop_token();
      else fin = ST_EXHAUST;
    end
    n = tok_start - from;
    nb = (n + 3) / 4;
    if (nb == 0 && fin != ST_RUNNING) nb = 1;
    for (int k = 0; k < nb; k++) begin
      c = (n - 4 * k > 4) ? 4 : n - 4 * k;
      e.b0 = (c > 0) ? rd(from + 4 * k) : 8'd0;
      e.b1 = (c > 1) ? rd(from + 4 * k + 1) : 8'd0;
      e.b2 = (c > 2) ? rd(from + 4 * k + 2) : 8'd0;
      e.b3 = (c > 3) ? rd(from + 4 * k + 3) : 8'd0;
      e.cnt = c[2:0];
      e.last = (k + 1 == nb);
      e.status = fin;
      e.len = 13'(from + 4 * k + c);
      beat_q.push_back(e);
    end
  endfunction

  always @(posedge clk) begin
    beat_t got, want;
    if (!rst_n) begin
      clear_page();
      beat_q.delete();
      fail_count <= 0;
      beats_pending <= 0;
    end else begin
      if (in_valid && !in_stall) decode_byte(in_packed_byte, in_first_of_page, in_last_of_page);
      if (out_valid && !out_stall) begin
        got = '{out_byte0, out_byte1, out_byte2, out_byte3, out_byte_count,
                out_run_last, out_page_status, out_page_length};
        if (beat_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected beat %p", got);
          fail_count <= fail_count + 1;
        end else begin
          want = beat_q.pop_front();
          if (got !== want) begin
            if (fail_count < 10) $display("beat mismatch: expected %p actual %p", want, got);
            fail_count <= fail_count + 1;
          end
        end
      end
      beats_pending <= beat_q.size();
    end
  end

endmodule

`default_nettype wire

[bench/lz_page_decompress_test.sv]
// ----------------------------------------------------------------------------
// lz_page_decompress_test
// Drives packed pages into the decompressor: directed tokens of every kind
// and edge case, then random well-formed pages with some noise, random gaps
// and stalls, and one long output hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module lz_page_decompress_test;
  import lzpd_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_packed_byte = '0;
  logic        in_first_of_page = 1'b0;
  logic        in_last_of_page = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_byte0, out_byte1, out_byte2, out_byte3;
  logic [2:0]  out_byte_count, out_page_status;
  logic        out_run_last;
  logic [12:0] out_page_length;
  int          fail_count, beats_pending;
  int          idle_cycles = 0;
  bit          hold_off = 1'b0;

  // Bytes of the page being assembled.
  logic [7:0] page_q[$];

  always #2 clk = ~clk;

  lz_page_decompress DUT (.*);

  lz_page_decompress_check checker_i (.*);

  // Count cycles with no request moving on either side; give up at the limit.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Receiver: random stalls per beat, plus one long hold-off when asked.
  initial begin
    int w;
    @(posedge rst_n);
    forever begin
      if (hold_off) begin
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
      w = (($urandom & 3) == 0) ? 0 : $urandom_range(0, 9);
      if (w > 0) begin
        out_stall <= 1'b1;
        repeat (w) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Offer one request and hold it until accepted.
  task automatic send_byte(logic [7:0] b, logic first, logic last, bit gaps);
    int w;
    w = gaps ? $urandom_range(0, 9) : 0;
    if (w > 0) begin
      in_valid <= 1'b0;
      repeat (w) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_packed_byte <= b;
    in_first_of_page <= first;
    in_last_of_page <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Send the queued page; first byte starts it, last ends it if asked.
  task automatic send_page(bit mark_last, bit gaps);
    foreach (page_q[i])
      send_byte(page_q[i], i == 0, mark_last && i == page_q.size() - 1, gaps);
    page_q.delete();
  endtask

  // Append a random well-formed token; pos tracks the bytes written so far.
  task automatic add_token(inout int pos);
    int kind, l, c, d;
    kind = $urandom_range(0, 4);
    case (kind)
      0: begin // run
        c = $urandom_range(1, 20);
        page_q.push_back(8'h00); page_q.push_back(c[7:0]); page_q.push_back(8'($urandom));
        pos += c;
      end
      1: begin // literals only
        l = $urandom_range(1, 63);
        page_q.push_back({l[5:0], TK_SHORT});
        repeat (l) page_q.push_back(8'($urandom));
        pos += l;
      end
      2: begin // short literals plus copy, 9-bit distance
        l = $urandom_range(0, 3); c = $urandom_range(0, 7);
        d = $urandom_range(0, (pos + l > 511) ? 511 : pos + l);
        page_q.push_back({d[0], c[2:0], l[1:0], TK_MID});
        page_q.push_back(d[8:1]);
        repeat (l) page_q.push_back(8'($urandom));
        pos += l + c + 3;
      end
      3: begin // copy only
        c = $urandom_range(0, 3);
        d = $urandom_range(0, (pos > 4095) ? 4095 : pos);
        page_q.push_back({d[3:0], c[1:0], TK_COPY});
        page_q.push_back(d[11:4]);
        pos += c + 3;
      end
      default: begin // long form
        l = $urandom_range(0, 15); c = $urandom_range(0, 63);
        d = $urandom_range(0, (pos + l > 4095) ? 4095 : pos + l);
        page_q.push_back({c[1:0], l[3:0], TK_LONG});
        page_q.push_back({d[3:0], c[5:2]});
        page_q.push_back(d[11:4]);
        repeat (l) page_q.push_back(8'($urandom));
        pos += l + c;
      end
    endcase
  endtask

  initial begin
    int pos, r;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: literals, overlapping copy, zero distance, run, end marker.
    page_q = '{8'hfc, 8'h00, 8'hff, 8'h5a};
    page_q.delete(); page_q.push_back({6'd3, TK_SHORT});
    page_q.push_back(8'h00); page_q.push_back(8'hff); page_q.push_back(8'ha5);
    page_q.push_back({1'b1, 3'd7, 2'd0, TK_MID}); page_q.push_back(8'h00);
    page_q.push_back({4'd0, 2'd3, TK_COPY}); page_q.push_back(8'h00);
    page_q.push_back(8'h00); page_q.push_back(8'd255); page_q.push_back(8'h3c);
    page_q.push_back(8'h00); page_q.push_back(8'h00);
    send_page(1'b0, 1'b0);
    send_byte(8'h77, 1'b0, 1'b0, 1'b0);           // ignored after page end
    // Distance too far back.
    page_q = '{8'h06, 8'h11, {4'hf, 2'd0, TK_COPY}, 8'hff};
    send_page(1'b1, 1'b0);
    // Truncated long header, then clean end after a literal.
    page_q = '{{2'd3, 4'd15, TK_LONG}, 8'hff};
    send_page(1'b1, 1'b1);
    page_q = '{8'h04, 8'h80};
    send_page(1'b1, 1'b1);
    // Fill the page exactly with runs of 255 then 16; then overflow one.
    for (int i = 0; i < 16; i++) begin
      page_q.push_back(8'h00); page_q.push_back(8'd255); page_q.push_back(i[7:0]);
    end
    page_q.push_back(8'h00); page_q.push_back(8'd16); page_q.push_back(8'hee);
    send_page(1'b1, 1'b0);
    for (int i = 0; i < 17; i++) begin
      page_q.push_back(8'h00); page_q.push_back(8'd255); page_q.push_back(8'h01);
    end
    send_page(1'b1, 1'b0);

    // Long receiver hold-off while the sender keeps offering.
    hold_off = 1'b1;
    pos = 0;
    repeat (6) add_token(pos);
    send_page(1'b1, 1'b0);

    // Random pages: mostly well-formed, some broken or noisy.
    r = 0;
    while (r < 30) begin
      pos = 0;
      repeat ($urandom_range(1, 5)) add_token(pos);
      case ($urandom_range(0, 9))
        0: repeat ($urandom_range(1, 4)) page_q.push_back(8'($urandom));
        1: page_q.push_back({6'($urandom_range(0, 63)), 2'b11});
        2: begin page_q.push_back(8'h00); page_q.push_back(8'h00); end
        default: ;
      endcase
      r += page_q.size();
      send_page($urandom_range(0, 3) != 0, ($urandom & 7) != 0);
    end
    in_valid <= 1'b0;

    repeat (2) @(posedge clk);
    while (beats_pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0 && beats_pending == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

`default_nettype wire
